FILE: rtl/ilha_pkg.sv
// Package: shared constants and types of the implicit-list heap allocator.
package ilha_pkg;

    localparam int SW             = 18;
    localparam int HEAP_WORDS_DEF = 16384;
    localparam int DSIZE          = 8;
    localparam int INIT_CHUNK     = 1 << 12;
    localparam int CHUNK_W        = 17;
    localparam logic [CHUNK_W-1:0] CHUNK_RESET = CHUNK_W'(INIT_CHUNK);
    localparam int CFG_AW         = 3;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OOM  = 2'd1,
        ST_ZERO = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_INIT,
        OP_ALLOC,
        OP_FREE
    } t_op;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [4:0] {
        S_INIT_P1, S_INIT_P2, S_INIT_E, S_IDLE,
        S_FIT_RD, S_FIT_CHK, S_GROW, S_G_H, S_G_F, S_G_E,
        S_M_RP, S_M_RN, S_M_DEC, S_M_WH, S_M_WF,
        S_C_H1, S_C_F1, S_C_H2, S_C_F2,
        S_FR_RD, S_FR_CHK, S_FR_F, S_DONE
    } t_state;

endpackage

FILE: rtl/ilha_if.sv
// Interfaces: request and response channels of the heap allocator.
interface ilha_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] request_bytes;
    logic [15:0] free_addr;
    modport source (output valid, command, request_bytes, free_addr, input ready);
    modport sink   (input valid, command, request_bytes, free_addr, output ready);
endinterface

interface ilha_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] payload_addr;
    logic [1:0]  status;
    modport source (output valid, payload_addr, status, input ready);
    modport sink   (input valid, payload_addr, status, output ready);
endinterface

FILE: rtl/implicit_list_heap_allocator.sv
// Heap allocator: boundary-tag implicit free list, first-fit, in one word memory.
// One transaction at a time through a single-port tag memory: each header read
// or tag write is one memory access. An allocate walks the blocks up to the fit,
// then tags the block, writes a free remainder when it splits, and grows the
// heap first when no block fits; a free walks the blocks up to the target, then
// frees it and merges it with free neighbours. Each transaction passes through
// idle before the next is taken. After reset the layout is written before the
// first request is taken. The response register lets a finished result wait.
module implicit_list_heap_allocator
    import ilha_pkg::*;
#(
    parameter int HEAP_WORDS = HEAP_WORDS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ilha_req_if.sink            i_req,
    ilha_rsp_if.source          o_rsp,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CFG_AW-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int AW = (HEAP_WORDS > 1) ? $clog2(HEAP_WORDS) : 1;
    localparam longint LIMIT_L = (longint'(HEAP_WORDS) * 4 < 65536) ?
                                 longint'(HEAP_WORDS) * 4 : 65536;
    localparam logic [SW:0] LIMIT = (SW+1)'(LIMIT_L);
    localparam logic [SW-1:0] BP_FIRST = SW'(DSIZE);
    localparam logic [SW-1:0] INIT_SZ  = SW'(INIT_CHUNK);
    localparam logic INIT_FITS = (LIMIT_L >= 16 + INIT_CHUNK);

    logic [31:0] r_mem [HEAP_WORDS];
    logic [31:0] r_rdata;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic [SW-1:0] r_bp, n_bp, r_size, n_size, r_asize, n_asize;
    logic [SW-1:0] r_break, n_break, r_prev, n_prev;
    logic [15:0] r_addr, n_addr, r_res_addr, n_res_addr;
    t_status r_res_st, n_res_st;
    logic r_out_valid;
    logic [15:0] r_out_addr;
    t_status r_out_st;
    logic [CHUNK_W-1:0] r_chunk;

    logic          w_we;
    logic [SW-1:0] w_addr;
    logic [31:0]   w_wdata;

    function automatic logic [31:0] f_tag(input logic [SW-1:0] sz, input logic used);
        f_tag = {{(32-SW){1'b0}}, sz[SW-1:3], 2'b00, used};
    endfunction

    function automatic logic [AW-1:0] f_word(input logic [SW-1:0] a);
        f_word = AW'(a >> 2);
    endfunction

    // shared decode
    logic [SW-1:0] w_rsz, w_ext, w_bytes, w_sz1, w_rem, w_req_asize, w_req_sum;
    logic [SW-4:0] w_ext_dw;
    logic [SW:0]   w_grow_end;
    logic          w_rused, w_split, w_accept, w_out_free;
    logic [SW-1:0] w_psz, w_nsz;

    assign w_rsz   = {r_rdata[SW-1:3], 3'b000};
    assign w_rused = r_rdata[0];
    assign w_psz   = {r_prev[SW-1:3], 3'b000};
    assign w_nsz   = w_rsz;
    assign w_ext   = (r_asize > SW'(r_chunk)) ? r_asize : SW'(r_chunk);
    assign w_ext_dw = w_ext[SW-1:3] + (SW-3)'(w_ext[2]);
    assign w_bytes = {w_ext_dw, 3'b000};
    assign w_grow_end = {1'b0, r_break} + {1'b0, w_bytes};
    assign w_rem   = r_size - r_asize;
    assign w_split = (w_rem >= SW'(2 * DSIZE));
    assign w_sz1   = w_split ? r_asize : r_size;
    assign w_accept = i_req.valid && i_req.ready;
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_req_sum = SW'(i_req.request_bytes) + SW'(15);
    assign w_req_asize = (i_req.request_bytes <= 16'(DSIZE)) ? SW'(2 * DSIZE) :
        {w_req_sum[SW-1:3], 3'b000};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT_P1: n_state = S_INIT_P2;
            S_INIT_P2: n_state = S_INIT_E;
            S_INIT_E:  n_state = INIT_FITS ? S_G_H : S_IDLE;
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req.command == CMD_FREE) n_state = S_FR_RD;
                    else if (i_req.request_bytes == '0) n_state = S_DONE;
                    else n_state = S_FIT_RD;
                end
            end
            S_FIT_RD:  n_state = (r_bp >= r_break) ? S_GROW : S_FIT_CHK;
            S_FIT_CHK: begin
                if (w_rsz == '0) n_state = S_GROW;
                else if (!w_rused && w_rsz >= r_asize) n_state = S_C_H1;
                else n_state = S_FIT_RD;
            end
            S_GROW:    n_state = (w_grow_end > LIMIT) ? S_DONE : S_G_H;
            S_G_H:     n_state = S_G_F;
            S_G_F:     n_state = S_G_E;
            S_G_E:     n_state = S_M_RP;
            S_M_RP:    n_state = S_M_RN;
            S_M_RN:    n_state = S_M_DEC;
            S_M_DEC: begin
                if (r_prev[0] && w_rused) begin
                    case (r_op)
                        OP_INIT:  n_state = S_IDLE;
                        OP_FREE:  n_state = S_DONE;
                        default:  n_state = S_C_H1;
                    endcase
                end else begin
                    n_state = S_M_WH;
                end
            end
            S_M_WH:    n_state = S_M_WF;
            S_M_WF: begin
                case (r_op)
                    OP_INIT:  n_state = S_IDLE;
                    OP_FREE:  n_state = S_DONE;
                    default:  n_state = S_C_H1;
                endcase
            end
            S_C_H1:    n_state = S_C_F1;
            S_C_F1:    n_state = w_split ? S_C_H2 : S_DONE;
            S_C_H2:    n_state = S_C_F2;
            S_C_F2:    n_state = S_DONE;
            S_FR_RD:   n_state = (r_bp >= r_break) ? S_DONE : S_FR_CHK;
            S_FR_CHK: begin
                if (w_rsz == '0) n_state = S_DONE;
                else if (r_bp == SW'(r_addr)) begin
                    n_state = (w_rused && r_bp != BP_FIRST) ? S_FR_F : S_DONE;
                end else if (r_bp > SW'(r_addr)) n_state = S_DONE;
                else n_state = S_FR_RD;
            end
            S_FR_F:    n_state = S_M_RP;
            S_DONE:    n_state = w_out_free ? S_IDLE : S_DONE;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_op = r_op;
        n_bp = r_bp;
        n_size = r_size;
        n_asize = r_asize;
        n_break = r_break;
        n_prev = r_prev;
        n_addr = r_addr;
        n_res_addr = r_res_addr;
        n_res_st = r_res_st;
        w_we = 1'b0;
        w_addr = '0;
        w_wdata = '0;
        case (r_state)
            S_INIT_P1: begin
                w_we = 1'b1; w_addr = SW'(4); w_wdata = f_tag(SW'(DSIZE), 1'b1);
                n_op = OP_INIT;
            end
            S_INIT_P2: begin
                w_we = 1'b1; w_addr = SW'(8); w_wdata = f_tag(SW'(DSIZE), 1'b1);
            end
            S_INIT_E: begin
                w_we = 1'b1; w_addr = SW'(12); w_wdata = f_tag('0, 1'b1);
                n_break = SW'(16);
                n_bp = SW'(16);
                n_size = INIT_SZ;
            end
            S_IDLE: begin
                n_bp = BP_FIRST;
                n_addr = i_req.free_addr;
                n_asize = w_req_asize;
                n_res_addr = '0;
                n_res_st = ST_OK;
                if (w_accept) begin
                    if (i_req.command == CMD_FREE) n_op = OP_FREE;
                    else begin
                        n_op = OP_ALLOC;
                        if (i_req.request_bytes == '0) n_res_st = ST_ZERO;
                    end
                end
            end
            S_FIT_RD, S_FR_RD: w_addr = r_bp - SW'(4);
            S_FIT_CHK: begin
                n_size = w_rsz;
                n_bp = r_bp + w_rsz;
                if (!w_rused && w_rsz >= r_asize && w_rsz != '0) n_bp = r_bp;
            end
            S_GROW: begin
                n_size = w_bytes;
                n_bp = r_break;
                if (w_grow_end > LIMIT) n_res_st = ST_OOM;
            end
            S_G_H: begin
                w_we = 1'b1; w_addr = r_bp - SW'(4); w_wdata = f_tag(r_size, 1'b0);
            end
            S_G_F: begin
                w_we = 1'b1; w_addr = r_bp + r_size - SW'(8);
                w_wdata = f_tag(r_size, 1'b0);
            end
            S_G_E: begin
                w_we = 1'b1; w_addr = r_bp + r_size - SW'(4); w_wdata = f_tag('0, 1'b1);
                n_break = r_bp + r_size;
            end
            S_M_RP: w_addr = r_bp - SW'(8);
            S_M_RN: begin
                n_prev = r_rdata[SW-1:0];
                w_addr = r_bp + r_size - SW'(4);
            end
            S_M_DEC: begin
                if (!r_prev[0] && w_rused) begin
                    n_bp = r_bp - w_psz;
                    n_size = r_size + w_psz;
                end else if (r_prev[0] && !w_rused) begin
                    n_size = r_size + w_nsz;
                end else if (!r_prev[0]) begin
                    n_bp = r_bp - w_psz;
                    n_size = r_size + w_psz + w_nsz;
                end
            end
            S_M_WH: begin
                w_we = 1'b1; w_addr = r_bp - SW'(4); w_wdata = f_tag(r_size, 1'b0);
            end
            S_M_WF: begin
                w_we = 1'b1; w_addr = r_bp + r_size - SW'(8);
                w_wdata = f_tag(r_size, 1'b0);
            end
            S_C_H1: begin
                w_we = 1'b1; w_addr = r_bp - SW'(4); w_wdata = f_tag(w_sz1, 1'b1);
                n_res_addr = r_bp[15:0];
                n_res_st = ST_OK;
            end
            S_C_F1: begin
                w_we = 1'b1; w_addr = r_bp + w_sz1 - SW'(8); w_wdata = f_tag(w_sz1, 1'b1);
            end
            S_C_H2: begin
                w_we = 1'b1; w_addr = r_bp + r_asize - SW'(4); w_wdata = f_tag(w_rem, 1'b0);
            end
            S_C_F2: begin
                w_we = 1'b1; w_addr = r_bp + r_size - SW'(8); w_wdata = f_tag(w_rem, 1'b0);
            end
            S_FR_CHK: begin
                n_size = w_rsz;
                n_bp = r_bp + w_rsz;
                if (r_bp == SW'(r_addr)) begin
                    n_bp = r_bp;
                    if (w_rused && r_bp != BP_FIRST && w_rsz != '0) begin
                        w_we = 1'b1; w_addr = r_bp - SW'(4);
                        w_wdata = f_tag(w_rsz, 1'b0);
                    end
                end
            end
            S_FR_F: begin
                w_we = 1'b1; w_addr = r_bp + r_size - SW'(8);
                w_wdata = f_tag(r_size, 1'b0);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[f_word(w_addr)] <= w_wdata;
        r_rdata <= r_mem[f_word(w_addr)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT_P1;
            r_op <= OP_INIT;
            r_out_valid <= 1'b0;
            r_chunk <= CHUNK_RESET;
        end else begin
            r_state <= n_state;
            r_op <= n_op;
            if (r_state == S_DONE && w_out_free) r_out_valid <= 1'b1;
            else if (o_rsp.ready) r_out_valid <= 1'b0;
            if (psel && penable && pwrite && !paddr[2]) r_chunk <= pwdata[CHUNK_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_bp <= n_bp;
        r_size <= n_size;
        r_asize <= n_asize;
        r_break <= n_break;
        r_prev <= n_prev;
        r_addr <= n_addr;
        r_res_addr <= n_res_addr;
        r_res_st <= n_res_st;
        if (r_state == S_DONE && w_out_free) begin
            r_out_addr <= r_res_addr;
            r_out_st <= r_res_st;
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.payload_addr = r_out_addr;
    assign o_rsp.status = r_out_st;
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{(32-CHUNK_W){1'b0}}, r_chunk};

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_req.ready)
        else $error("ready held after accepting a transaction");
    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_OK) |-> o_rsp.payload_addr == '0)
        else $error("failed request returned an address");
    a_addr_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> o_rsp.payload_addr[2:0] == 3'b000)
        else $error("payload address not double-word aligned");
    a_break_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ({1'b0, r_break} <= LIMIT && r_break[2:0] == 3'b000))
        else $error("heap break out of range");

endmodule
